/* hw/rtl/hbd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the Hill birth-death stochastic step.
// No dependencies; used by every module of the block.
package hbd_pkg;

	// Field and register widths
	localparam int COUNT_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int DRAW_BITS  = 32;
	localparam int RUN_BITS   = 20;
	localparam int TIME_BITS  = 32;
	localparam int RATE_BITS  = 24;
	localparam int SIZE_BITS  = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	// Datapath widths
	localparam int Y_BITS    = 32;
	localparam int Y2_BITS   = 48;
	localparam int Y3_BITS   = 48;
	localparam int DEN_BITS  = 49;
	localparam int H_BITS    = 17;
	localparam int AH_BITS   = 41;
	localparam int R_BITS    = 42;
	localparam int TOT_BITS  = 43;
	localparam int LN_BITS   = 37;
	localparam int LOGV_BITS = 38;
	localparam int DT_BITS   = 37;

	// Serial divider sizing
	localparam int DIV_REM_BITS = 49;
	localparam int DIV_NUM_BITS = 40;
	localparam int DIV_CNT_BITS = 6;

	localparam logic [DIV_CNT_BITS-1:0] STEPS_XW = 6'd32;
	localparam logic [DIV_CNT_BITS-1:0] STEPS_H  = 6'd16;
	localparam logic [DIV_CNT_BITS-1:0] STEPS_DT = 6'd37;
	localparam logic [DIV_CNT_BITS-1:0] STEPS_BR = 6'd32;

	// ln(2) in Q.26
	localparam logic [25:0] LN2_Q26 = 26'd46516320;

	// Register reset values
	localparam logic [SIZE_BITS-1:0]  RST_SIZE  = 16'd90;
	localparam logic [RATE_BITS-1:0]  RST_INPUT = 24'd7864;
	localparam logic [RATE_BITS-1:0]  RST_BASAL = 24'd32768;
	localparam logic [RATE_BITS-1:0]  RST_MAXR  = 24'd196608;
	localparam logic [RATE_BITS-1:0]  RST_HALF  = 24'd589824;
	localparam logic [TIME_BITS-1:0]  RST_LIMIT = 32'd131072000;
	localparam logic [COUNT_BITS-1:0] RST_INIT  = 16'd135;
	localparam logic [RUN_BITS-1:0]   RST_RUNS  = 20'd100000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SYSTEM_SIZE   = 3'd0,
		REG_INPUT_LEVEL   = 3'd1,
		REG_BASAL_RATE    = 3'd2,
		REG_MAX_RATE      = 3'd3,
		REG_HALF_SAT      = 3'd4,
		REG_TIME_LIMIT    = 3'd5,
		REG_INITIAL_COUNT = 3'd6,
		REG_RUN_COUNT     = 3'd7
	} cfg_idx_e;

	typedef struct packed {
		logic [SIZE_BITS-1:0]  system_size;
		logic [RATE_BITS-1:0]  input_level;
		logic [RATE_BITS-1:0]  basal_rate;
		logic [RATE_BITS-1:0]  max_rate;
		logic [RATE_BITS-1:0]  half_sat;
		logic [TIME_BITS-1:0]  time_limit;
		logic [COUNT_BITS-1:0] initial_count;
		logic [RUN_BITS-1:0]   run_count;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic ld_y;
		logic ld_sq;
		logic ld_ca;
		logic ld_cb;
		logic ld_cube;
		logic h_zero;
		logic h_one;
		logic ld_h;
		logic ld_ah;
		logic ld_r;
		logic ld_tot;
		logic start_h;
		logic start_dt;
		logic ld_dt;
		logic set_birth;
		logic start_br;
		logic ld_birth;
		logic commit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic log_done;
		logic den_zero;
		logic k_zero;
		logic total_zero;
		logic x_zero;
		logic ends;
		logic out_full;
	} sts_t;

endpackage

/* hw/rtl/hbd_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by all divides.
// Depends on hbd_pkg.
module hbd_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [hbd_pkg::DIV_REM_BITS-1:0] rem_init,
	input  logic [hbd_pkg::DIV_NUM_BITS-1:0] num,
	input  logic [hbd_pkg::DEN_BITS-1:0]     den,
	input  logic [hbd_pkg::DIV_CNT_BITS-1:0] steps,
	output logic [hbd_pkg::DIV_NUM_BITS-1:0] quo,
	output logic [hbd_pkg::DIV_REM_BITS-1:0] rem,
	output logic done
);
	import hbd_pkg::*;

	logic [DIV_REM_BITS-1:0] rem_q;
	logic [DIV_NUM_BITS-1:0] num_q;
	logic [DIV_NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0]     den_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DIV_REM_BITS:0]   trial;
	logic [DIV_REM_BITS:0]   diff;
	logic                    ge;

	// Trial subtract of the shifted remainder
	assign trial = {rem_q, num_q[DIV_NUM_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Payload shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			num_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_BITS-2:0], 1'b0};
			quo_q <= {quo_q[DIV_NUM_BITS-2:0], ge};
			rem_q <= ge ? diff[DIV_REM_BITS-1:0] : trial[DIV_REM_BITS-1:0];
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

/* hw/rtl/hbd_log.sv */
`timescale 1ns / 1ps
// Natural log of the inverse time draw: leading-one normalize, 32 squaring
// steps for the log2 fraction, then a split constant multiply by ln 2.
// Depends on hbd_pkg.
module hbd_log (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [hbd_pkg::DRAW_BITS-1:0] draw,
	output logic [hbd_pkg::LN_BITS-1:0]   ln,
	output logic valid
);
	import hbd_pkg::*;

	logic [DRAW_BITS-1:0] v;
	logic [4:0]           lead;
	logic [31:0]          norm;
	logic [31:0]          m_q;
	logic [31:0]          frac_q;
	logic [4:0]           e_q;
	logic [5:0]           cnt_q;
	logic                 busy_q;
	logic                 valid_q;
	logic [63:0]          sq;
	logic [32:0]          sq_sh;
	logic [LOGV_BITS-1:0] lval;
	logic [41:0]          plo_q;
	logic [47:0]          phi_q;
	logic [63:0]          lsum;
	logic [LN_BITS-1:0]   ln_q;

	// Zero draw counts as one
	assign v = (draw == '0) ? {{(DRAW_BITS-1){1'b0}}, 1'b1} : draw;

	// Leading one and normalize into [2^31, 2^32)
	always_comb begin
		lead = '0;
		for (int i = 0; i < DRAW_BITS; i++) begin
			if (v[i]) lead = 5'(i);
		end
	end
	assign norm = v << (5'd31 - lead);

	// One squaring step
	assign sq    = 64'(m_q) * 64'(m_q);
	assign sq_sh = sq[63:31];

	// -log2 in Q.32: 32.0 minus the log2 of the draw
	assign lval = {1'b1, 37'd0} - {1'b0, e_q, frac_q};
	assign lsum = {phi_q, 16'd0} + {22'd0, plo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 6'd34) begin
				busy_q  <= 1'b0;
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q    <= norm;
			e_q    <= lead;
			frac_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 6'd32) begin
				frac_q <= {frac_q[30:0], sq_sh[32]};
				m_q    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
			end
			if (cnt_q == 6'd32) plo_q <= 42'(lval[15:0]) * 42'(LN2_Q26);
			if (cnt_q == 6'd33) phi_q <= 48'(lval[37:16]) * 48'(LN2_Q26);
			if (cnt_q == 6'd34) ln_q  <= lsum[62:26];
		end
	end

	assign ln    = ln_q;
	assign valid = valid_q;

endmodule

/* hw/rtl/hbd_dp.sv */
`timescale 1ns / 1ps
// Datapath: Hill propensity, waiting time, branch choice, run state and
// the output register. Depends on hbd_pkg, hbd_div and hbd_log.
module hbd_dp (
	input  logic clk,
	input  logic arst_n,
	input  hbd_pkg::cfg_t cfg,
	input  hbd_pkg::cmd_t cmd,
	output hbd_pkg::sts_t sts,
	input  logic [hbd_pkg::DRAW_BITS-1:0]  time_draw,
	input  logic [hbd_pkg::DRAW_BITS-1:0]  branch_draw,
	output logic out_valid,
	input  logic out_ready,
	output logic [hbd_pkg::COUNT_BITS-1:0] final_count,
	output logic [hbd_pkg::RUN_BITS-1:0]   run_number,
	output logic last_run
);
	import hbd_pkg::*;

	// Run state
	logic [COUNT_BITS-1:0] count_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [RUN_BITS-1:0]   runs_q;

	// Work registers
	logic [DRAW_BITS-1:0] d2_q;
	logic [Y_BITS-1:0]    y_q;
	logic [Y2_BITS-1:0]   y2_q;
	logic [63:0]          plo_q;
	logic [47:0]          phi_q;
	logic [Y3_BITS-1:0]   y3_q;
	logic [DEN_BITS-1:0]  den_q;
	logic [H_BITS-1:0]    h_q;
	logic [AH_BITS-1:0]   ah_q;
	logic [R_BITS-1:0]    r_q;
	logic [TOT_BITS-1:0]  tot_q;
	logic [DT_BITS-1:0]   dt_q;
	logic                 birth_q;

	// Output register
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic [RUN_BITS-1:0]   out_run_q;
	logic                  out_last_q;

	logic [SIZE_BITS-1:0]     w_eff;
	logic                     div_start;
	logic [DIV_REM_BITS-1:0]  div_rem_in;
	logic [DIV_NUM_BITS-1:0]  div_num_in;
	logic [DEN_BITS-1:0]      div_den_in;
	logic [DIV_CNT_BITS-1:0]  div_steps;
	logic [DIV_NUM_BITS-1:0]  div_quo;
	logic [DIV_REM_BITS-1:0]  div_rem;
	logic                     div_done;
	logic [LN_BITS-1:0]       ln;
	logic                     ln_valid;

	logic [Y_BITS:0]          y_sum;
	logic [63:0]              y_sq;
	logic [79:0]              cube;
	logic [Y3_BITS-1:0]       y3_new;
	logic [25:0]              rate_sum;
	logic                     branch_up;
	logic [DT_BITS:0]         t_sum;
	logic [TIME_BITS-1:0]     t_new;
	logic                     birth;
	logic [COUNT_BITS-1:0]    x_new;
	logic                     ends;
	logic                     last;

	// Zero system size counts as one
	assign w_eff = (cfg.system_size == '0) ? 16'd1 : cfg.system_size;

	// Divider operand select
	assign div_start = cmd.load_item | cmd.start_h | cmd.start_dt | cmd.start_br;
	always_comb begin
		div_rem_in = '0;
		div_num_in = '0;
		div_den_in = {33'd0, w_eff};
		div_steps  = STEPS_XW;
		if (cmd.load_item) begin
			div_num_in = {count_q, 24'd0};
		end else if (cmd.start_h) begin
			div_rem_in = {1'b0, y3_q};
			div_den_in = den_q;
			div_steps  = STEPS_H;
		end else if (cmd.start_dt) begin
			div_num_in = {ln, 3'd0};
			div_den_in = {6'd0, tot_q};
			div_steps  = STEPS_DT;
		end else if (cmd.start_br) begin
			div_rem_in = {7'd0, r_q};
			div_den_in = {6'd0, tot_q};
			div_steps  = STEPS_BR;
		end
	end

	hbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem_in),
		.num      (div_num_in),
		.den      (div_den_in),
		.steps    (div_steps),
		.quo      (div_quo),
		.rem      (div_rem),
		.done     (div_done)
	);

	hbd_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load_item),
		.draw   (time_draw),
		.ln     (ln),
		.valid  (ln_valid)
	);

	// Concentration, square and cube
	assign y_sum  = {9'd0, cfg.input_level} + {1'b0, div_quo[31:0]};
	assign y_sq   = 64'(y_q) * 64'(y_q);
	assign cube   = {phi_q, 32'd0} + {16'd0, plo_q};
	assign y3_new = (cube[79:64] != '0) ? '1 : cube[63:16];
	assign rate_sum = {2'b0, cfg.basal_rate} + {1'b0, ah_q[40:16]};

	// Reaction choice from the fractional divide
	assign branch_up = (d2_q < div_quo[31:0]) ||
		((d2_q == div_quo[31:0]) && (div_rem != '0));

	// Update of time and count
	assign t_sum = {{(DT_BITS+1-TIME_BITS){1'b0}}, time_q} + {1'b0, dt_q};
	always_comb begin
		if (tot_q == '0) t_new = '1;
		else if (t_sum[DT_BITS:TIME_BITS] != '0) t_new = '1;
		else t_new = t_sum[TIME_BITS-1:0];
	end
	assign birth = (tot_q != '0) && birth_q;
	always_comb begin
		if (birth) x_new = (count_q == '1) ? count_q : count_q + 1'b1;
		else x_new = (count_q == '0) ? count_q : count_q - 1'b1;
	end
	assign ends = t_new >= cfg.time_limit;
	assign last = ({1'b0, runs_q} + 21'd1) >= {1'b0, cfg.run_count};

	// Work registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) d2_q <= branch_draw;
		if (cmd.ld_y) y_q <= (y_sum[Y_BITS] != 1'b0) ? '1 : y_sum[Y_BITS-1:0];
		if (cmd.ld_sq) y2_q <= y_sq[63:16];
		if (cmd.ld_ca) plo_q <= 64'(y2_q[31:0]) * 64'(y_q);
		if (cmd.ld_cb) phi_q <= 48'(y2_q[47:32]) * 48'(y_q);
		if (cmd.ld_cube) begin
			y3_q  <= y3_new;
			den_q <= {25'd0, cfg.half_sat} + {1'b0, y3_new};
		end
		if (cmd.h_zero) h_q <= '0;
		else if (cmd.h_one) h_q <= {1'b1, 16'd0};
		else if (cmd.ld_h) h_q <= div_quo[H_BITS-1:0];
		if (cmd.ld_ah) ah_q <= 41'(cfg.max_rate) * 41'(h_q);
		if (cmd.ld_r) r_q <= 42'(w_eff) * 42'(rate_sum);
		if (cmd.ld_tot) tot_q <= {1'b0, r_q} + {11'd0, count_q, 16'd0};
		if (cmd.ld_dt) dt_q <= div_quo[DT_BITS-1:0];
		if (cmd.set_birth) birth_q <= 1'b1;
		else if (cmd.ld_birth) birth_q <= branch_up;
	end

	// Run state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= RST_INIT;
			time_q      <= '0;
			runs_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.commit) begin
				if (ends) begin
					count_q     <= cfg.initial_count;
					time_q      <= '0;
					runs_q      <= last ? '0 : runs_q + 1'b1;
					out_valid_q <= 1'b1;
				end else begin
					count_q <= x_new;
					time_q  <= t_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && ends) begin
			out_count_q <= x_new;
			out_run_q   <= runs_q;
			out_last_q  <= last;
		end
	end

	assign sts.div_done   = div_done;
	assign sts.log_done   = ln_valid;
	assign sts.den_zero   = (den_q == '0);
	assign sts.k_zero     = (cfg.half_sat == '0);
	assign sts.total_zero = (tot_q == '0);
	assign sts.x_zero     = (count_q == '0);
	assign sts.ends       = ends;
	assign sts.out_full   = out_valid_q;

	assign out_valid   = out_valid_q;
	assign final_count = out_count_q;
	assign run_number  = out_run_q;
	assign last_run    = out_last_q;

endmodule

/* hw/rtl/hbd_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for one reaction: steps the datapath through its divides,
// multiplies and the final update. Depends on hbd_pkg.
module hbd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  hbd_pkg::sts_t sts,
	output hbd_pkg::cmd_t cmd
);
	import hbd_pkg::*;

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_XW    = 15'b000000000000010,
		ST_SQ    = 15'b000000000000100,
		ST_CA    = 15'b000000000001000,
		ST_CB    = 15'b000000000010000,
		ST_CUBE  = 15'b000000000100000,
		ST_HSEL  = 15'b000000001000000,
		ST_HDIV  = 15'b000000010000000,
		ST_RA    = 15'b000000100000000,
		ST_RB    = 15'b000001000000000,
		ST_TOT   = 15'b000010000000000,
		ST_LWAIT = 15'b000100000000000,
		ST_DT    = 15'b001000000000000,
		ST_BR    = 15'b010000000000000,
		ST_UPD   = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = ST_XW;
				end
			end
			ST_XW: begin
				if (sts.div_done) begin
					cmd.ld_y = 1'b1;
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.ld_sq = 1'b1;
				state_d = ST_CA;
			end
			ST_CA: begin
				cmd.ld_ca = 1'b1;
				state_d = ST_CB;
			end
			ST_CB: begin
				cmd.ld_cb = 1'b1;
				state_d = ST_CUBE;
			end
			ST_CUBE: begin
				cmd.ld_cube = 1'b1;
				state_d = ST_HSEL;
			end
			ST_HSEL: begin
				if (sts.den_zero) begin
					cmd.h_zero = 1'b1;
					state_d = ST_RA;
				end else if (sts.k_zero) begin
					cmd.h_one = 1'b1;
					state_d = ST_RA;
				end else begin
					cmd.start_h = 1'b1;
					state_d = ST_HDIV;
				end
			end
			ST_HDIV: begin
				if (sts.div_done) begin
					cmd.ld_h = 1'b1;
					state_d = ST_RA;
				end
			end
			ST_RA: begin
				cmd.ld_ah = 1'b1;
				state_d = ST_RB;
			end
			ST_RB: begin
				cmd.ld_r = 1'b1;
				state_d = ST_TOT;
			end
			ST_TOT: begin
				cmd.ld_tot = 1'b1;
				state_d = ST_LWAIT;
			end
			ST_LWAIT: begin
				if (sts.total_zero) begin
					state_d = ST_UPD;
				end else if (sts.log_done) begin
					cmd.start_dt = 1'b1;
					state_d = ST_DT;
				end
			end
			ST_DT: begin
				if (sts.div_done) begin
					cmd.ld_dt = 1'b1;
					if (sts.x_zero) begin
						cmd.set_birth = 1'b1;
						state_d = ST_UPD;
					end else begin
						cmd.start_br = 1'b1;
						state_d = ST_BR;
					end
				end
			end
			ST_BR: begin
				if (sts.div_done) begin
					cmd.ld_birth = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				// hold while a finished run waits on a full output register
				if (!sts.ends || !sts.out_full) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/hill_birth_death_ssa_step.sv */
`timescale 1ns / 1ps
// One Gillespie reaction per input transfer; a result when a run ends.
// One item at a time: a new transfer is taken only once the previous reaction has updated.
// Steps: divider passes for x/w, the Hill fraction, the waiting time and the branch, each
// seen done by its state, plus the control states; fewer when a divide is skipped. The log
// unit runs beside the first divides. A waiting result holds the update until it is taken.
// Reset: state machine idle, count 135, time and runs zero, output invalid, registers reset.
module hill_birth_death_ssa_step (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata, // time_draw[31:0], branch_draw[63:32]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata, // final_count[15:0], run_number[35:16], zero pad
	output logic m_tlast,        // last_run
	input  logic cfg_we,
	input  logic [hbd_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [hbd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import hbd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic [COUNT_BITS-1:0] final_count;
	logic [RUN_BITS-1:0]   run_number;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.system_size   <= RST_SIZE;
			cfg_q.input_level   <= RST_INPUT;
			cfg_q.basal_rate    <= RST_BASAL;
			cfg_q.max_rate      <= RST_MAXR;
			cfg_q.half_sat      <= RST_HALF;
			cfg_q.time_limit    <= RST_LIMIT;
			cfg_q.initial_count <= RST_INIT;
			cfg_q.run_count     <= RST_RUNS;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SYSTEM_SIZE:   cfg_q.system_size   <= cfg_data[SIZE_BITS-1:0];
				REG_INPUT_LEVEL:   cfg_q.input_level   <= cfg_data[RATE_BITS-1:0];
				REG_BASAL_RATE:    cfg_q.basal_rate    <= cfg_data[RATE_BITS-1:0];
				REG_MAX_RATE:      cfg_q.max_rate      <= cfg_data[RATE_BITS-1:0];
				REG_HALF_SAT:      cfg_q.half_sat      <= cfg_data[RATE_BITS-1:0];
				REG_TIME_LIMIT:    cfg_q.time_limit    <= cfg_data[TIME_BITS-1:0];
				REG_INITIAL_COUNT: cfg_q.initial_count <= cfg_data[COUNT_BITS-1:0];
				REG_RUN_COUNT:     cfg_q.run_count     <= cfg_data[RUN_BITS-1:0];
				default: ;
			endcase
		end
	end

	hbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hbd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.time_draw   (s_tdata[31:0]),
		.branch_draw (s_tdata[63:32]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.final_count (final_count),
		.run_number  (run_number),
		.last_run    (m_tlast)
	);

	assign m_tdata = {4'd0, run_number, final_count};

	// Busy after every accepted transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a reaction is in flight");

	// A result appears only from an update
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.commit))
		else $error("result raised without an update");

	// An update never overwrites a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && sts.ends) |-> !sts.out_full)
		else $error("result register overwritten");

endmodule

/* verif/hill_birth_death_ssa_step_tb.sv */
`timescale 1ns / 1ps
// Testbench for hill_birth_death_ssa_step: directed stimulus table, then random phases.
// Depends on hbd_pkg and the block RTL; each ended run is checked against an in-bench predictor or a typed result.
module hill_birth_death_ssa_step_tb;
	import hbd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0; // time_draw[31:0], branch_draw[63:32]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;      // final_count[15:0], run_number[35:16], zero pad
	logic m_tlast;             // last_run
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	hill_birth_death_ssa_step DUT (.*);

	always #2 clk = ~clk;

	typedef struct {
		logic [COUNT_BITS-1:0] count;
		logic [RUN_BITS-1:0]   run;
		logic                  last;
	} run_end_t;

	typedef struct {
		bit        is_cfg;
		cfg_idx_e  idx;
		logic [31:0] val;
		logic [31:0] d1, d2;
		bit        typed;
		run_end_t  res;
	} row_t;

	run_end_t run_ends_q[$];
	row_t plan[$];
	int fails = 0;
	bit quiet = 0;

	// shadow registers and run state
	logic [15:0] w_reg = RST_SIZE;
	logic [23:0] u_reg = RST_INPUT, a0_reg = RST_BASAL, a_reg = RST_MAXR, k_reg = RST_HALF;
	logic [31:0] tlim_reg = RST_LIMIT;
	logic [15:0] init_reg = RST_INIT;
	logic [19:0] nruns_reg = RST_RUNS;
	logic [15:0] count_st = RST_INIT;
	logic [63:0] time_st = '0;
	logic [19:0] done_st = '0;

	// -log2(v / 2^32) in Q.32
	function automatic logic [63:0] neg_log2(input logic [31:0] v);
		int e;
		logic [127:0] m;
		logic [31:0] frac;
		e = 0;
		frac = '0;
		for (int i = 0; i < 32; i++)
			if (v[i]) e = i;
		m = 128'(v) << (31 - e);
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (128'd1 << 32)) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (64'd32 << 32) - ((64'(e) << 32) | 64'(frac));
	endfunction

	// one reaction; returns 1 when the run ends
	function automatic bit react(input logic [31:0] d1, input logic [31:0] d2,
			output run_end_t res);
		logic [127:0] w, x, y, y2, y3, den, h, r, total, ln, dt;
		bit birth;
		w = (w_reg != 0) ? 128'(w_reg) : 128'd1;
		x = 128'(count_st);
		y = 128'(u_reg) + ((x << 16) / w);
		if (y > 128'hFFFF_FFFF) y = 128'hFFFF_FFFF;
		y2 = (y * y) >> 16;
		y3 = y2 * y;
		y3 = (y3 > 128'hFFFF_FFFF_FFFF_FFFF) ? (128'hFFFF_FFFF_FFFF_FFFF >> 16) : (y3 >> 16);
		den = 128'(k_reg) + y3;
		if (den == 0) h = 0;
		else if (k_reg == 0) h = 128'd1 << 16;
		else h = (y3 << 16) / den;
		r = w * (128'(a0_reg) + ((128'(a_reg) * h) >> 16));
		total = r + (x << 16);
		if (total == 0) begin
			time_st = 64'hFFFF_FFFF;
			birth = 0;
		end else begin
			ln = (128'(neg_log2((d1 != 0) ? d1 : 32'd1)) * 128'(LN2_Q26)) >> 26;
			dt = ((ln << 16) / total) >> 16;
			time_st = (128'(time_st) + dt > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF
				: time_st + 64'(dt);
			birth = (128'(d2) * total) < (r << 32);
		end
		if (birth) begin
			if (count_st != 16'hFFFF) count_st++;
		end else if (count_st != 0) count_st--;
		if (time_st >= 64'(tlim_reg)) begin
			res.count = count_st;
			res.run = done_st;
			res.last = (21'(done_st) + 21'd1) >= 21'(nruns_reg);
			done_st = res.last ? '0 : done_st + 20'd1;
			count_st = init_reg;
			time_st = '0;
			return 1;
		end
		return 0;
	endfunction

	task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SYSTEM_SIZE:   w_reg = val[15:0];
			REG_INPUT_LEVEL:   u_reg = val[23:0];
			REG_BASAL_RATE:    a0_reg = val[23:0];
			REG_MAX_RATE:      a_reg = val[23:0];
			REG_HALF_SAT:      k_reg = val[23:0];
			REG_TIME_LIMIT:    tlim_reg = val;
			REG_INITIAL_COUNT: init_reg = val[15:0];
			default:           nruns_reg = val[19:0];
		endcase
	endtask

	// wait out all pending run ends plus in-flight reactions that end no run
	task automatic drain();
		s_tvalid <= 1'b0;
		cfg_we <= 1'b0;
		@(posedge clk);
		while (run_ends_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// one input transfer; typed result overrides the predictor when given
	task automatic send(input logic [31:0] d1, input logic [31:0] d2,
			input bit typed, input run_end_t tres);
		run_end_t res;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {d2, d1};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (react(d1, d2, res)) run_ends_q.push_back(typed ? tres : res);
	endtask

	function automatic void add_cfg(cfg_idx_e idx, logic [31:0] val);
		row_t r;
		r = '{idx: REG_SYSTEM_SIZE, default: '0};
		r.is_cfg = 1;
		r.idx = idx;
		r.val = val;
		plan.push_back(r);
	endfunction

	function automatic void add_item(logic [31:0] d1, logic [31:0] d2, bit typed,
			logic [15:0] c, logic [19:0] n, logic l);
		row_t r;
		r = '{idx: REG_SYSTEM_SIZE, default: '0};
		r.d1 = d1;
		r.d2 = d2;
		r.typed = typed;
		r.res = '{c, n, l};
		plan.push_back(r);
	endfunction

	function automatic logic [31:0] draw();
		case ($urandom_range(0, 15))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// result side: random stall bursts
	initial begin
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		run_end_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (run_ends_q.size() == 0) begin
				$error("unexpected result transfer: final_count %0d run_number %0d",
					m_tdata[15:0], m_tdata[35:16]);
				fails++;
			end else begin
				e = run_ends_q.pop_front();
				if (m_tdata[15:0] !== e.count) begin
					$error("final_count expected %0d actual %0d", e.count, m_tdata[15:0]);
					fails++;
				end
				if (m_tdata[35:16] !== e.run) begin
					$error("run_number expected %0d actual %0d", e.run, m_tdata[35:16]);
					fails++;
				end
				if (m_tlast !== e.last) begin
					$error("last_run expected %0d actual %0d", e.last, m_tlast);
					fails++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		run_end_t none;
		bit mid;
		int n;
		none = '{default: '0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every reaction ends a run while the limit is zero
		add_cfg(REG_TIME_LIMIT, 0);
		add_cfg(REG_RUN_COUNT, 3);
		add_item(32'd1, 32'd0, 1, 16'd136, 20'd0, 1'b0);
		add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'd134, 20'd1, 1'b0);
		add_item(32'd0, 32'd0, 1, 16'd136, 20'd2, 1'b1);
		// run count zero: every run is last
		add_cfg(REG_RUN_COUNT, 0);
		add_item(32'h8000_0000, 32'd0, 1, 16'd136, 20'd0, 1'b1);
		// new initial count applies from the following run; count saturates at max
		add_cfg(REG_INITIAL_COUNT, 32'hFFFF);
		add_item(32'h1234_5678, 32'h0000_9ABC, 0, 0, 0, 0);
		add_item(32'd1, 32'd0, 1, 16'hFFFF, 20'd0, 1'b1);
		// no reaction possible: count held at zero
		add_cfg(REG_INITIAL_COUNT, 0);
		add_cfg(REG_BASAL_RATE, 0);
		add_cfg(REG_MAX_RATE, 0);
		add_item(32'd5, 32'd5, 0, 0, 0, 0);
		add_item(32'd5, 32'hFFFF_FFFF, 1, 16'd0, 20'd0, 1'b1);
		// zero system size treated as one
		add_cfg(REG_SYSTEM_SIZE, 0);
		add_cfg(REG_BASAL_RATE, 32'h1_0000);
		add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'd1, 20'd0, 1'b1);
		// register extremes
		add_cfg(REG_INPUT_LEVEL, 32'hFF_FFFF);
		add_cfg(REG_HALF_SAT, 32'hFF_FFFF);
		add_cfg(REG_MAX_RATE, 32'hFF_FFFF);
		add_cfg(REG_SYSTEM_SIZE, 32'hFFFF);
		add_cfg(REG_RUN_COUNT, 32'hF_FFFF);
		add_cfg(REG_TIME_LIMIT, 32'hFFFF_FFFF);
		add_item(32'd1, 32'h7FFF_FFFF, 0, 0, 0, 0);
		add_item(32'hFFFF_FFFF, 32'd0, 0, 0, 0, 0);
		add_item(32'h0000_FFFF, 32'hFFFF_0000, 0, 0, 0, 0);
		add_cfg(REG_TIME_LIMIT, 0);
		add_cfg(REG_HALF_SAT, 0);
		add_item(32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0);
		add_item(32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0);
		add_cfg(REG_RUN_COUNT, 2);
		add_item(32'd3, 32'd1, 0, 0, 0, 0);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (i == 0 || !plan[i-1].is_cfg) drain();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				if (i > 0 && plan[i-1].is_cfg) cfg_we <= 1'b0;
				send(plan[i].d1, plan[i].d2, plan[i].typed, plan[i].res);
			end
		end

		// random phases; the first and last push register extremes
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(REG_SYSTEM_SIZE, (ph == 0) ? 32'hFFFF : (ph == 5) ? 32'd1
				: $urandom_range(1, 200));
			write_reg(REG_INPUT_LEVEL, (ph == 0) ? 32'hFF_FFFF : $urandom_range(0, 32'h4_0000));
			write_reg(REG_BASAL_RATE, (ph == 5) ? 32'd0 : $urandom_range(0, 32'h8_0000));
			write_reg(REG_MAX_RATE, (ph == 0) ? 32'hFF_FFFF : $urandom_range(0, 32'h8_0000));
			write_reg(REG_HALF_SAT, (ph == 5) ? 32'hFF_FFFF : $urandom_range(0, 32'h40_0000));
			write_reg(REG_TIME_LIMIT, (ph == 0) ? 32'd1 : $urandom_range(0, 6000));
			write_reg(REG_INITIAL_COUNT, (ph == 5) ? 32'hFFFE : $urandom_range(0, 300));
			write_reg(REG_RUN_COUNT, (ph == 0) ? 32'd0 : $urandom_range(1, 6));
			cfg_we <= 1'b0;
			quiet = (ph == 5);
			n = (ph == 5) ? 238 : 237;
			for (int k = 0; k < n; k++) begin
				mid = (ph == 2 && k == 100);
				if (mid) drain();
				send(draw(), draw(), 0, none);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (run_ends_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* hill_birth_death_ssa_step.f */
hw/rtl/hbd_pkg.sv
hw/rtl/hbd_div.sv
hw/rtl/hbd_log.sv
hw/rtl/hbd_dp.sv
hw/rtl/hbd_ctrl.sv
hw/rtl/hill_birth_death_ssa_step.sv
verif/hill_birth_death_ssa_step_tb.sv
